// ----- sv/tss_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the tile sum image similarity block
package tss_pkg;

    localparam int MAX_TILES_X_DEF = 512;
    localparam int DIM_MAX         = 4096;
    localparam int REGION_MAX      = 256;
    localparam int EPOCH_W         = 8;
    localparam int FIFO_DEPTH      = 4;
    localparam int SUM_W           = 24;
    localparam int CNT_W           = 25;
    localparam int Q_W             = 17;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] REG_WIDTH     = 2'd0;
    localparam logic [1:0] REG_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_REGION    = 2'd2;
    localparam logic [1:0] REG_THRESHOLD = 2'd3;

    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  b;
        logic        start;
        logic [11:0] tile_col;
        logic        tile_end;
        logic        do_acc;
        logic        last;
        logic        err;
    } item_t;

    typedef struct packed {
        logic [SUM_W-1:0] threshold;
        logic [CNT_W-1:0] total;
    } cfg_t;

    typedef struct packed {
        logic             err;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] kept;
    } div_req_t;

endpackage

// ----- sv/tss_fifo.sv -----
`timescale 1ns / 1ps
// short item queue between the front and back parts
module tss_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  tss_pkg::item_t wr_item,
    output logic          full,
    input  logic          rd_en,
    output tss_pkg::item_t rd_item,
    output logic          empty
);
    import tss_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    item_t         slot_reg [FIFO_DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [PW:0]   fill_reg;

    assign full    = fill_reg == (PW+1)'(FIFO_DEPTH);
    assign empty   = fill_reg == '0;
    assign rd_item = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wp_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (rd_en)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ----- sv/tss_front.sv -----
`timescale 1ns / 1ps
// front part: config registers, tile count setup, raster position and item classification
module tss_front
#(
    parameter int MAX_TILES_X = tss_pkg::MAX_TILES_X_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write,
    input  logic [1:0]     cfg_index,
    input  logic [23:0]    cfg_data,
    input  logic           push,
    input  logic [7:0]     pixel_a,
    input  logic [7:0]     pixel_b,
    input  logic           frame_start,
    input  logic           fifo_full,
    input  logic           sweeping,
    output logic           full,
    output logic           item_wr,
    output tss_pkg::item_t item,
    output tss_pkg::cfg_t  cfg
);
    import tss_pkg::*;

    localparam logic [1:0] CALC_IDLE = 2'd0;
    localparam logic [1:0] CALC_LOAD = 2'd1;
    localparam logic [1:0] CALC_DIV  = 2'd2;
    localparam logic [1:0] CALC_MUL  = 2'd3;

    logic [12:0] fw_reg;
    logic [12:0] fh_reg;
    logic [8:0]  rs_reg;
    logic [23:0] thr_reg;

    logic [1:0]  calc_state_reg;
    logic        phase_y_reg;
    logic [3:0]  bit_cnt_reg;
    logic [12:0] num_reg;
    logic [8:0]  rem_reg;
    logic [12:0] q_reg;
    logic [12:0] tx_reg;
    logic [12:0] ty_reg;
    logic [CNT_W-1:0] total_reg;
    logic        err_reg;

    logic [11:0] col_reg;
    logic [11:0] row_reg;
    logic [7:0]  cwt_reg;
    logic [7:0]  rwt_reg;
    logic [11:0] tc_reg;

    logic [12:0] w;
    logic [12:0] h;
    logic [8:0]  r;
    logic [9:0]  trial;
    logic        ge;
    logic [8:0]  rem_next;
    logic [12:0] q_next;

    logic [11:0] cur_col;
    logic [11:0] cur_row;
    logic [7:0]  cur_cwt;
    logic [7:0]  cur_rwt;
    logic [11:0] cur_tc;
    logic        last_col;
    logic        last_row;
    logic        tce;
    logic        tre;
    logic        accept;

    // clamped geometry
    always_comb
    begin
        w = (fw_reg == '0) ? 13'd1 : (fw_reg > 13'(DIM_MAX)) ? 13'(DIM_MAX) : fw_reg;
        h = (fh_reg == '0) ? 13'd1 : (fh_reg > 13'(DIM_MAX)) ? 13'(DIM_MAX) : fh_reg;
        r = (rs_reg == '0) ? 9'd1 : (rs_reg > 9'(REGION_MAX)) ? 9'(REGION_MAX) : rs_reg;
    end

    // one quotient bit per cycle for the ceiling divisions
    always_comb
    begin
        trial    = {rem_reg, num_reg[12]};
        ge       = trial >= {1'b0, r};
        rem_next = ge ? 9'(trial - {1'b0, r}) : trial[8:0];
        q_next   = {q_reg[11:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg         <= 13'd640;
            fh_reg         <= 13'd480;
            rs_reg         <= 9'd8;
            thr_reg        <= '0;
            calc_state_reg <= CALC_LOAD;
            phase_y_reg    <= 1'b0;
            bit_cnt_reg    <= '0;
            err_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_WIDTH:     fw_reg  <= cfg_data[12:0];
                    REG_HEIGHT:    fh_reg  <= cfg_data[12:0];
                    REG_REGION:    rs_reg  <= cfg_data[8:0];
                    REG_THRESHOLD: thr_reg <= cfg_data;
                    default:       thr_reg <= thr_reg;
                endcase
                calc_state_reg <= CALC_LOAD;
                phase_y_reg    <= 1'b0;
            end
            else
            begin
                case (calc_state_reg)
                    CALC_LOAD:
                    begin
                        num_reg        <= phase_y_reg ? 13'(h + {4'b0, r} - 13'd1)
                                                      : 13'(w + {4'b0, r} - 13'd1);
                        rem_reg        <= '0;
                        q_reg          <= '0;
                        bit_cnt_reg    <= '0;
                        calc_state_reg <= CALC_DIV;
                    end
                    CALC_DIV:
                    begin
                        rem_reg     <= rem_next;
                        q_reg       <= q_next;
                        num_reg     <= {num_reg[11:0], 1'b0};
                        bit_cnt_reg <= bit_cnt_reg + 1'b1;
                        if (bit_cnt_reg == 4'd12)
                        begin
                            if (phase_y_reg)
                            begin
                                ty_reg         <= q_next;
                                calc_state_reg <= CALC_MUL;
                            end
                            else
                            begin
                                tx_reg         <= q_next;
                                phase_y_reg    <= 1'b1;
                                calc_state_reg <= CALC_LOAD;
                            end
                        end
                    end
                    CALC_MUL:
                    begin
                        total_reg      <= CNT_W'(tx_reg * ty_reg);
                        err_reg        <= tx_reg > 13'(MAX_TILES_X);
                        phase_y_reg    <= 1'b0;
                        calc_state_reg <= CALC_IDLE;
                    end
                    default:
                    begin
                        calc_state_reg <= CALC_IDLE;
                    end
                endcase
            end
        end
    end

    assign full   = fifo_full || sweeping || (calc_state_reg != CALC_IDLE);
    assign accept = push && !full;

    // raster position of this beat
    always_comb
    begin
        cur_col  = frame_start ? '0 : col_reg;
        cur_row  = frame_start ? '0 : row_reg;
        cur_cwt  = frame_start ? '0 : cwt_reg;
        cur_rwt  = frame_start ? '0 : rwt_reg;
        cur_tc   = frame_start ? '0 : tc_reg;
        last_col = {1'b0, cur_col} >= 13'(w - 13'd1);
        last_row = {1'b0, cur_row} >= 13'(h - 13'd1);
        tce      = last_col || ({1'b0, cur_cwt} >= 9'(r - 9'd1));
        tre      = last_row || ({1'b0, cur_rwt} >= 9'(r - 9'd1));
    end

    always_comb
    begin
        item.a        = pixel_a;
        item.b        = pixel_b;
        item.start    = frame_start;
        item.tile_col = cur_tc;
        item.tile_end = tce && tre;
        item.do_acc   = !err_reg && ({1'b0, cur_tc} < 13'(MAX_TILES_X));
        item.last     = last_col && last_row;
        item.err      = err_reg;
    end

    assign item_wr       = accept;
    assign cfg.threshold = thr_reg;
    assign cfg.total     = total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            cwt_reg <= '0;
            rwt_reg <= '0;
            tc_reg  <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                cwt_reg <= '0;
                tc_reg  <= '0;
                if (last_row)
                begin
                    row_reg <= '0;
                    rwt_reg <= '0;
                end
                else
                begin
                    row_reg <= cur_row + 1'b1;
                    rwt_reg <= tre ? '0 : cur_rwt + 1'b1;
                end
            end
            else
            begin
                col_reg <= cur_col + 1'b1;
                row_reg <= cur_row;
                rwt_reg <= cur_rwt;
                if (tce)
                begin
                    cwt_reg <= '0;
                    tc_reg  <= cur_tc + 1'b1;
                end
                else
                begin
                    cwt_reg <= cur_cwt + 1'b1;
                    tc_reg  <= cur_tc;
                end
            end
        end
    end

endmodule

// ----- sv/tss_back.sv -----
`timescale 1ns / 1ps
// back part: tile sum store, per-tile compare and differing count
module tss_back
#(
    parameter int MAX_TILES_X = tss_pkg::MAX_TILES_X_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fifo_empty,
    input  tss_pkg::item_t    head,
    input  tss_pkg::cfg_t     cfg,
    input  logic              div_ready,
    output logic              fifo_pop,
    output logic              sweeping,
    output logic              div_start,
    output tss_pkg::div_req_t div_req
);
    import tss_pkg::*;

    localparam int AW = (MAX_TILES_X > 1) ? $clog2(MAX_TILES_X) : 1;
    localparam int EW = EPOCH_W + 2 * SUM_W;

    logic [EW-1:0]      mem [MAX_TILES_X];
    logic [EW-1:0]      rd_reg;

    logic               sweep_reg;
    logic [AW-1:0]      sweep_addr_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               acc_valid_reg;
    logic [11:0]        acc_tc_reg;
    logic [SUM_W-1:0]   acc_a_reg;
    logic [SUM_W-1:0]   acc_b_reg;
    logic               fetched_reg;
    logic               start_done_reg;

    logic               active;
    logic               do_start;
    logic               hit;
    logic               need_fetch;
    logic               do_fetch;
    logic               can_go;
    logic               rd_live;
    logic [SUM_W-1:0]   base_a;
    logic [SUM_W-1:0]   base_b;
    logic [SUM_W-1:0]   sa;
    logic [SUM_W-1:0]   sb;
    logic [SUM_W-1:0]   diff;
    logic [SUM_W-1:0]   wa;
    logic [SUM_W-1:0]   wb;
    logic               cnt_inc;
    logic [CNT_W-1:0]   cnt_new;
    logic [CNT_W-1:0]   capped;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [EW-1:0]      mem_wd;
    logic [EPOCH_W-1:0] epoch_inc;

    always_comb
    begin
        active     = !fifo_empty && !sweep_reg;
        do_start   = active && head.start && !start_done_reg;
        hit        = acc_valid_reg && (acc_tc_reg == head.tile_col);
        need_fetch = head.do_acc && !hit && !fetched_reg;
        do_fetch   = active && !do_start && need_fetch;
        can_go     = active && !do_start && !need_fetch && (!head.last || div_ready);
        epoch_inc  = epoch_reg + 1'b1;

        // stale tags read as zero sums
        rd_live = rd_reg[EW-1 -: EPOCH_W] == epoch_reg;
        base_a  = fetched_reg ? (rd_live ? rd_reg[2*SUM_W-1:SUM_W] : '0) : acc_a_reg;
        base_b  = fetched_reg ? (rd_live ? rd_reg[SUM_W-1:0] : '0) : acc_b_reg;
        sa      = base_a + {16'b0, head.a};
        sb      = base_b + {16'b0, head.b};
        diff    = (sa > sb) ? sa - sb : sb - sa;
        cnt_inc = head.do_acc && head.tile_end && (diff > cfg.threshold)
                  && (cnt_reg != CNT_MAX);
        cnt_new = cnt_inc ? cnt_reg + 1'b1 : cnt_reg;
        wa      = head.tile_end ? '0 : sa;
        wb      = head.tile_end ? '0 : sb;
        capped  = (cnt_new > cfg.total) ? cfg.total : cnt_new;

        if (sweep_reg)
        begin
            mem_we = 1'b1;
            mem_wa = sweep_addr_reg;
            mem_wd = {epoch_reg, {(2*SUM_W){1'b0}}};
        end
        else
        begin
            mem_we = can_go && head.do_acc;
            mem_wa = head.tile_col[AW-1:0];
            mem_wd = {epoch_reg, wa, wb};
        end
    end

    assign fifo_pop      = can_go;
    assign sweeping      = sweep_reg;
    assign div_start     = can_go && head.last;
    assign div_req.err   = head.err;
    assign div_req.count = cnt_new;
    assign div_req.total = cfg.total;
    assign div_req.kept  = cfg.total - capped;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (do_fetch)
        begin
            rd_reg <= mem[head.tile_col[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            epoch_reg      <= '0;
            cnt_reg        <= '0;
            acc_valid_reg  <= 1'b0;
            fetched_reg    <= 1'b0;
            start_done_reg <= 1'b0;
        end
        else
        begin
            if (sweep_reg)
            begin
                if (sweep_addr_reg == AW'(MAX_TILES_X - 1))
                begin
                    sweep_reg      <= 1'b0;
                    sweep_addr_reg <= '0;
                end
                else
                begin
                    sweep_addr_reg <= sweep_addr_reg + 1'b1;
                end
            end

            if (do_start)
            begin
                epoch_reg      <= epoch_inc;
                acc_valid_reg  <= 1'b0;
                cnt_reg        <= '0;
                start_done_reg <= 1'b1;
                if (epoch_inc == '0)
                begin
                    sweep_reg <= 1'b1;
                end
            end

            if (do_fetch)
            begin
                fetched_reg <= 1'b1;
            end

            if (can_go)
            begin
                fetched_reg    <= 1'b0;
                start_done_reg <= 1'b0;
                cnt_reg        <= head.last ? '0 : cnt_new;
                if (head.do_acc)
                begin
                    acc_valid_reg <= 1'b1;
                    acc_tc_reg    <= head.tile_col;
                    acc_a_reg     <= wa;
                    acc_b_reg     <= wb;
                end
            end
        end
    end

endmodule

// ----- sv/tss_div.sv -----
`timescale 1ns / 1ps
// end of frame similarity divider and result register
module tss_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tss_pkg::div_req_t req,
    output logic              ready,
    input  logic              pop,
    output logic              empty,
    output logic [24:0]       differing_tiles,
    output logic [24:0]       total_tiles,
    output logic [16:0]       similarity_q16,
    output logic              config_error
);
    import tss_pkg::*;

    logic             busy_reg;
    logic             valid_reg;
    logic [4:0]       step_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] den_reg;
    logic [Q_W-1:0]   q_reg;
    logic [CNT_W-1:0] cnt_out_reg;
    logic [CNT_W-1:0] total_out_reg;
    logic             err_out_reg;

    logic [CNT_W:0]   trial;
    logic             ge;

    always_comb
    begin
        trial = (step_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        ge    = trial >= {1'b0, den_reg};
    end

    assign ready           = !busy_reg && !valid_reg;
    assign empty           = !valid_reg;
    assign differing_tiles = cnt_out_reg;
    assign total_tiles     = total_out_reg;
    assign similarity_q16  = q_reg;
    assign config_error    = err_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                cnt_out_reg   <= req.err ? '0 : req.count;
                total_out_reg <= req.err ? '0 : req.total;
                err_out_reg   <= req.err;
                q_reg         <= '0;
                rem_reg       <= req.kept;
                den_reg       <= req.total;
                step_reg      <= '0;
                busy_reg      <= !req.err;
                valid_reg     <= req.err;
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? CNT_W'(trial - {1'b0, den_reg}) : trial[CNT_W-1:0];
                q_reg    <= {q_reg[Q_W-2:0], ge};
                step_reg <= step_reg + 1'b1;
                if (step_reg == 5'(Q_W - 1))
                begin
                    busy_reg  <= 1'b0;
                    valid_reg <= 1'b1;
                end
            end
            else if (pop && valid_reg)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- sv/tile_sum_image_similarity.sv -----
`timescale 1ns / 1ps
// top level of the tile sum image similarity block
//
//  channel   handshake          payload
//  pixels    push / full        pixel_a, pixel_b, frame_start
//  results   empty / pop        differing_tiles, total_tiles, similarity_q16, config_error
//  config    cfg_write          cfg_index, cfg_data
//
// a pixel beat first fetches its tile column from the tile sum store when that column
// differs from the last one accumulated (first beat of each tile in a row); a frame start also takes a step of its own
// each config write rebuilds the tile counts by two ceiling divisions and a product, full is high meanwhile
// after reset the tile sum store is cleared, and again
// once every 256 frame starts when the frame tag wraps
// the frame result leaves the divider once all 17 bits of similarity_q16 are formed after the frame's last beat
module tile_sum_image_similarity
#(
    parameter int MAX_TILES_X = tss_pkg::MAX_TILES_X_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  pixel_a,
    input  logic [7:0]  pixel_b,
    input  logic        frame_start,
    output logic        empty,
    input  logic        pop,
    output logic [24:0] differing_tiles,
    output logic [24:0] total_tiles,
    output logic [16:0] similarity_q16,
    output logic        config_error
);
    import tss_pkg::*;

    item_t    wr_item;
    item_t    head;
    cfg_t     cfg;
    div_req_t div_req;
    logic     item_wr;
    logic     fifo_full;
    logic     fifo_empty;
    logic     fifo_pop;
    logic     sweeping;
    logic     div_ready;
    logic     div_start;

    tss_front #(.MAX_TILES_X(MAX_TILES_X)) u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .pixel_a     (pixel_a),
        .pixel_b     (pixel_b),
        .frame_start (frame_start),
        .fifo_full   (fifo_full),
        .sweeping    (sweeping),
        .full        (full),
        .item_wr     (item_wr),
        .item        (wr_item),
        .cfg         (cfg)
    );

    tss_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (item_wr),
        .wr_item (wr_item),
        .full    (fifo_full),
        .rd_en   (fifo_pop),
        .rd_item (head),
        .empty   (fifo_empty)
    );

    tss_back #(.MAX_TILES_X(MAX_TILES_X)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .head       (head),
        .cfg        (cfg),
        .div_ready  (div_ready),
        .fifo_pop   (fifo_pop),
        .sweeping   (sweeping),
        .div_start  (div_start),
        .div_req    (div_req)
    );

    tss_div u_div
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (div_start),
        .req             (div_req),
        .ready           (div_ready),
        .pop             (pop),
        .empty           (empty),
        .differing_tiles (differing_tiles),
        .total_tiles     (total_tiles),
        .similarity_q16  (similarity_q16),
        .config_error    (config_error)
    );

endmodule
